>>> hw/rtl/thumb_data_processing_execute_assert.svh
// Assertion macros for the Thumb data-processing execute block
`ifndef THUMB_DATA_PROCESSING_EXECUTE_ASSERT_SVH
`define THUMB_DATA_PROCESSING_EXECUTE_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define TDP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define TDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tdpe_pkg.sv
// ----------------------------------------------------------------------------
// tdpe_pkg
// Shared types, constants and functions of the Thumb data-processing execute block.
// ----------------------------------------------------------------------------
package tdpe_pkg;

    localparam int unsigned NumRegs   = 8;
    localparam int unsigned RegIdxW   = 3;
    localparam int unsigned DataW     = 32;
    localparam int unsigned InstrW    = 16;
    localparam int unsigned ExtraW    = 3;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [3:0] ALU_AND = 4'h0;
    localparam logic [3:0] ALU_EOR = 4'h1;
    localparam logic [3:0] ALU_LSL = 4'h2;
    localparam logic [3:0] ALU_LSR = 4'h3;
    localparam logic [3:0] ALU_ASR = 4'h4;
    localparam logic [3:0] ALU_ADC = 4'h5;
    localparam logic [3:0] ALU_SBC = 4'h6;
    localparam logic [3:0] ALU_ROR = 4'h7;
    localparam logic [3:0] ALU_TST = 4'h8;
    localparam logic [3:0] ALU_NEG = 4'h9;
    localparam logic [3:0] ALU_CMP = 4'hA;
    localparam logic [3:0] ALU_CMN = 4'hB;
    localparam logic [3:0] ALU_ORR = 4'hC;
    localparam logic [3:0] ALU_MUL = 4'hD;
    localparam logic [3:0] ALU_BIC = 4'hE;
    localparam logic [3:0] ALU_MVN = 4'hF;

    localparam logic [1:0] IMM_MOV = 2'd0;
    localparam logic [1:0] IMM_CMP = 2'd1;
    localparam logic [1:0] IMM_ADD = 2'd2;
    localparam logic [1:0] IMM_SUB = 2'd3;

    localparam logic [2:0] MUL_CYC_V5 = 3'd3;

    typedef struct packed {
        logic              recognized;
        logic              write_enable;
        logic [2:0]        dest_index;
        logic [31:0]       result_value;
        logic              flag_n;
        logic              flag_z;
        logic              flag_c;
        logic              flag_v;
        logic [2:0]        extra_cycles;
    } t_result;

    typedef struct packed {
        logic [31:0] value;
        logic        carry;
    } t_shift;

    function automatic t_shift shift_op(input logic [1:0] kind, input logic [31:0] v,
                                        input logic [7:0] s, input logic cin);
        t_shift      r;
        logic [63:0] w;
        logic [4:0]  s5;
        r.value = v;
        r.carry = cin;
        s5 = s[4:0];
        if (s != 8'd0) begin
            case (kind)
                SH_LSL: begin
                    if (s < 8'd32) begin
                        w = {32'd0, v} << s5;
                        r.value = w[31:0];
                        r.carry = w[32];
                    end else begin
                        r.value = '0;
                        r.carry = (s == 8'd32) ? v[0] : 1'b0;
                    end
                end
                SH_LSR: begin
                    if (s < 8'd32) begin
                        w = {v, 32'd0} >> s5;
                        r.value = w[63:32];
                        r.carry = w[31];
                    end else begin
                        r.value = '0;
                        r.carry = (s == 8'd32) ? v[31] : 1'b0;
                    end
                end
                SH_ASR: begin
                    if (s < 8'd32) begin
                        w = $signed({v, 32'd0}) >>> s5;
                        r.value = w[63:32];
                        r.carry = w[31];
                    end else begin
                        r.value = {32{v[31]}};
                        r.carry = v[31];
                    end
                end
                default: begin
                    w = {v, v} >> s5;
                    r.value = w[31:0];
                    r.carry = w[31];
                end
            endcase
        end
        return r;
    endfunction

    function automatic logic [2:0] mul_cycles(input logic [31:0] x);
        logic [2:0] c;
        if (x[31:8] == 24'd0 || x[31:8] == 24'hFFFFFF) begin
            c = 3'd1;
        end else if (x[31:16] == 16'd0 || x[31:16] == 16'hFFFF) begin
            c = 3'd2;
        end else if (x[31:24] == 8'd0 || x[31:24] == 8'hFF) begin
            c = 3'd3;
        end else begin
            c = 3'd4;
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/tdpe_instr_if.sv
// ----------------------------------------------------------------------------
// tdpe_instr_if
// Instruction channel: valid/ready handshake with a 16-bit instruction beat.
// ----------------------------------------------------------------------------
interface tdpe_instr_if;
    logic        valid;
    logic        ready;
    logic [15:0] instruction_word;
    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

>>> hw/rtl/tdpe_result_if.sv
// ----------------------------------------------------------------------------
// tdpe_result_if
// Result channel: valid/ready handshake carrying one execute result beat.
// ----------------------------------------------------------------------------
interface tdpe_result_if;
    logic        valid;
    logic        ready;
    logic        recognized;
    logic        write_enable;
    logic [2:0]  dest_index;
    logic [31:0] result_value;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
    logic [2:0]  extra_cycles;
    modport source (output valid, output recognized, output write_enable,
                    output dest_index, output result_value, output flag_n,
                    output flag_z, output flag_c, output flag_v,
                    output extra_cycles, input ready);
    modport sink   (input valid, input recognized, input write_enable,
                    input dest_index, input result_value, input flag_n,
                    input flag_z, input flag_c, input flag_v,
                    input extra_cycles, output ready);
endinterface

>>> hw/rtl/tdpe_regfile.sv
// ----------------------------------------------------------------------------
// tdpe_regfile
// Low register file: two synchronous read ports, one write port, valid bits so
// that a register reads as zero until written.
// ----------------------------------------------------------------------------
module tdpe_regfile #(
    parameter int unsigned NUM_REGS = tdpe_pkg::NumRegs
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [$clog2(NUM_REGS)-1:0] i_raddr_a,
    input  logic [$clog2(NUM_REGS)-1:0] i_raddr_b,
    output logic [31:0]                 o_rdata_a,
    output logic [31:0]                 o_rdata_b,
    input  logic                        i_we,
    input  logic [$clog2(NUM_REGS)-1:0] i_waddr,
    input  logic [31:0]                 i_wdata
);
    logic [31:0] mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;

    logic [31:0] r_ra, r_rb;
    logic        r_va, r_vb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_ra <= mem[i_raddr_a];
        r_rb <= mem[i_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_va <= r_valid[i_raddr_a];
            r_vb <= r_valid[i_raddr_b];
        end
    end

    assign o_rdata_a = r_va ? r_ra : 32'd0;
    assign o_rdata_b = r_vb ? r_rb : 32'd0;
endmodule

>>> hw/rtl/tdpe_alu.sv
// ----------------------------------------------------------------------------
// tdpe_alu
// Decode and execute one instruction on its operands and the current flags.
// ----------------------------------------------------------------------------
module tdpe_alu (
    input  logic [15:0]        i_instr,
    input  logic [31:0]        i_rs,
    input  logic [31:0]        i_rd,
    input  logic [3:0]         i_flags,
    input  logic               i_core_variant,
    output tdpe_pkg::t_result  o_res
);
    logic [31:0] add_a, add_b, val;
    logic        add_cin, use_add, rec, we, nzset, fc;
    logic [32:0] sum;
    logic [2:0]  d, ext;
    logic [31:0] prod;
    tdpe_pkg::t_shift sh;
    logic        fn, fz, fv;

    always_comb begin
        add_a = i_rs; add_b = 32'd0; add_cin = 1'b0; use_add = 1'b0;
        rec = 1'b0; we = 1'b0; d = 3'd0; ext = 3'd0; val = 32'd0;
        nzset = 1'b0; fc = i_flags[1];
        sh = tdpe_pkg::shift_op(tdpe_pkg::SH_LSL, 32'd0, 8'd0, i_flags[1]);
        prod = i_rd * i_rs;
        if (i_instr[15:13] == 3'b000 && i_instr[12:11] != 2'b11) begin
            sh = tdpe_pkg::shift_op(i_instr[12:11], i_rs,
                     (i_instr[12:11] != tdpe_pkg::SH_LSL && i_instr[10:6] == 5'd0)
                     ? 8'd32 : {3'd0, i_instr[10:6]}, i_flags[1]);
            val = sh.value; fc = sh.carry; nzset = 1'b1;
            rec = 1'b1; we = 1'b1; d = i_instr[2:0];
        end else if (i_instr[15:11] == 5'b00011) begin
            add_a = i_rs;
            add_b = i_instr[10] ? {29'd0, i_instr[8:6]} : i_rd;
            if (i_instr[9]) begin
                add_b = ~add_b; add_cin = 1'b1;
            end
            use_add = 1'b1; rec = 1'b1; we = 1'b1; d = i_instr[2:0];
        end else if (i_instr[15:13] == 3'b001) begin
            rec = 1'b1; we = 1'b1; d = i_instr[10:8];
            add_a = i_rd;
            case (i_instr[12:11])
                tdpe_pkg::IMM_MOV: begin
                    val = {24'd0, i_instr[7:0]}; nzset = 1'b1;
                end
                tdpe_pkg::IMM_ADD: begin
                    add_b = {24'd0, i_instr[7:0]}; use_add = 1'b1;
                end
                tdpe_pkg::IMM_CMP: begin
                    add_b = ~{24'd0, i_instr[7:0]}; add_cin = 1'b1;
                    use_add = 1'b1; we = 1'b0;
                end
                default: begin
                    add_b = ~{24'd0, i_instr[7:0]}; add_cin = 1'b1; use_add = 1'b1;
                end
            endcase
        end else if (i_instr[15:10] == 6'b010000) begin
            rec = 1'b1; we = 1'b1; d = i_instr[2:0];
            add_a = i_rd;
            case (i_instr[9:6])
                tdpe_pkg::ALU_AND: begin val = i_rd & i_rs; nzset = 1'b1; end
                tdpe_pkg::ALU_EOR: begin val = i_rd ^ i_rs; nzset = 1'b1; end
                tdpe_pkg::ALU_LSL, tdpe_pkg::ALU_LSR, tdpe_pkg::ALU_ASR,
                tdpe_pkg::ALU_ROR: begin
                    sh = tdpe_pkg::shift_op((i_instr[9:6] == tdpe_pkg::ALU_ROR)
                             ? tdpe_pkg::SH_ROR : 2'(i_instr[9:6] - 4'd2),
                             i_rd, i_rs[7:0], i_flags[1]);
                    val = sh.value; fc = sh.carry; nzset = 1'b1; ext = 3'd1;
                end
                tdpe_pkg::ALU_ADC: begin
                    add_b = i_rs; add_cin = i_flags[1]; use_add = 1'b1;
                end
                tdpe_pkg::ALU_SBC: begin
                    add_b = ~i_rs; add_cin = i_flags[1]; use_add = 1'b1;
                end
                tdpe_pkg::ALU_TST: begin
                    val = i_rd & i_rs; nzset = 1'b1; we = 1'b0;
                end
                tdpe_pkg::ALU_NEG: begin
                    add_a = 32'd0; add_b = ~i_rs; add_cin = 1'b1; use_add = 1'b1;
                end
                tdpe_pkg::ALU_CMP: begin
                    add_b = ~i_rs; add_cin = 1'b1; use_add = 1'b1; we = 1'b0;
                end
                tdpe_pkg::ALU_CMN: begin
                    add_b = i_rs; use_add = 1'b1; we = 1'b0;
                end
                tdpe_pkg::ALU_ORR: begin val = i_rd | i_rs; nzset = 1'b1; end
                tdpe_pkg::ALU_MUL: begin
                    val = prod; nzset = 1'b1;
                    ext = i_core_variant ? tdpe_pkg::MUL_CYC_V5
                                         : tdpe_pkg::mul_cycles(i_rs);
                end
                tdpe_pkg::ALU_BIC: begin val = i_rd & ~i_rs; nzset = 1'b1; end
                default: begin val = ~i_rs; nzset = 1'b1; end
            endcase
        end
        sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
        fn = i_flags[3]; fz = i_flags[2]; fv = i_flags[0];
        if (use_add) begin
            val = sum[31:0];
            fc = sum[32];
            fv = (add_a[31] ^ sum[31]) & (add_b[31] ^ sum[31]);
            nzset = 1'b1;
        end
        if (nzset) begin
            fn = val[31]; fz = (val == 32'd0);
        end
        o_res.recognized   = rec;
        o_res.write_enable = we;
        o_res.dest_index   = d;
        o_res.result_value = val;
        o_res.flag_n       = fn;
        o_res.flag_z       = fz;
        o_res.flag_c       = fc;
        o_res.flag_v       = fv;
        o_res.extra_cycles = ext;
    end
endmodule

>>> hw/rtl/thumb_data_processing_execute.sv
// ----------------------------------------------------------------------------
// thumb_data_processing_execute
// Thumb low-register data-processing execute stage with register file memory.
// ----------------------------------------------------------------------------
// Usage: instruction beats enter on i_instr (valid/ready); one result beat
// leaves on o_result for each instruction. Stage 1 reads the two source
// registers from the register file memory (a registered read) and
// rereads them while it holds; stage 2 executes and writes the destination
// back, forwarding a write to a following read of the same register. The
// result beat passes from stage 1 into the result register, which drives
// o_result; throughput is one instruction per cycle while results are taken.
// Flags live in a register updated in stage 2. The result register is the
// output stage; while it holds and the receiver stalls, stage 1 and the input
// stall behind it. Reset clears the pipeline, the flags, core_variant and the
// register valid bits, so every register reads as zero until written. Write
// core_variant via i_cfg_we only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "thumb_data_processing_execute_assert.svh"

module thumb_data_processing_execute #(
    parameter int unsigned NUM_REGS = tdpe_pkg::NumRegs
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    tdpe_instr_if.sink           i_instr,
    tdpe_result_if.source        o_result
);
    localparam int unsigned AW = $clog2(NUM_REGS);

    logic        r_core_variant;
    logic [3:0]  r_flags;
    logic        r_s1_valid, r_out_valid;
    logic [15:0] r_s1_instr;
    tdpe_pkg::t_result r_out, alu_res;

    logic [31:0] rf_a, rf_b, op_rs, op_rd;
    logic        r_fwd_a, r_fwd_b;
    logic [31:0] r_fwd_data;
    logic        adv_out, adv_s1, wr;
    logic [AW-1:0] ra_a, ra_b;
    logic [15:0] iw;

    assign adv_out = r_s1_valid && (!r_out_valid || o_result.ready);
    assign adv_s1  = !r_s1_valid || adv_out;
    assign i_instr.ready = adv_s1;
    assign wr = adv_out && alu_res.write_enable;

    assign iw = adv_s1 ? i_instr.instruction_word : r_s1_instr;
    // rs: bits 5:3 always; rd: 10:8 for immediates, 8:6 for register add, else 2:0
    assign ra_a = AW'(iw[5:3]);
    assign ra_b = (iw[15:13] == 3'b001) ? AW'(iw[10:8]) :
                  (iw[15:11] == 5'b00011) ? AW'(iw[8:6]) : AW'(iw[2:0]);

    tdpe_regfile #(.NUM_REGS(NUM_REGS)) u_rf (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_raddr_a(ra_a), .i_raddr_b(ra_b),
        .o_rdata_a(rf_a), .o_rdata_b(rf_b),
        .i_we(wr), .i_waddr(AW'(alu_res.dest_index)), .i_wdata(alu_res.result_value)
    );

    always_ff @(posedge i_clk) begin
        if (adv_s1) begin
            r_fwd_a <= wr && (AW'(alu_res.dest_index) == ra_a);
            r_fwd_b <= wr && (AW'(alu_res.dest_index) == ra_b);
            r_fwd_data <= alu_res.result_value;
            r_s1_instr <= iw;
        end else begin
            if (wr) begin
                r_fwd_a <= 1'b0;
                r_fwd_b <= 1'b0;
            end
        end
    end

    assign op_rs = r_fwd_a ? r_fwd_data : rf_a;
    assign op_rd = r_fwd_b ? r_fwd_data : rf_b;

    tdpe_alu u_alu (
        .i_instr(r_s1_instr), .i_rs(op_rs), .i_rd(op_rd), .i_flags(r_flags),
        .i_core_variant(r_core_variant), .o_res(alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (adv_out) begin
            r_out <= alu_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_variant <= 1'b0;
            r_flags        <= 4'd0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_core_variant <= i_cfg_wdata;
            end
            if (adv_out) begin
                r_flags <= {alu_res.flag_n, alu_res.flag_z, alu_res.flag_c, alu_res.flag_v};
            end
            if (adv_s1) begin
                r_s1_valid <= i_instr.valid;
            end
            if (adv_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.recognized   = r_out.recognized;
    assign o_result.write_enable = r_out.write_enable;
    assign o_result.dest_index   = r_out.dest_index;
    assign o_result.result_value = r_out.result_value;
    assign o_result.flag_n       = r_out.flag_n;
    assign o_result.flag_z       = r_out.flag_z;
    assign o_result.flag_c       = r_out.flag_c;
    assign o_result.flag_v       = r_out.flag_v;
    assign o_result.extra_cycles = r_out.extra_cycles;

    `TDP_ASSERT_IMPLY(a_unrec_quiet, i_clk, i_rst_n,
        o_result.valid && !o_result.recognized,
        !o_result.write_enable && o_result.extra_cycles == 3'd0,
        "unrecognized instruction reported a write or cycles")
    `TDP_ASSERT_NEXT(a_stall_holds_s1, i_clk, i_rst_n,
        r_s1_valid && r_out_valid && !o_result.ready,
        r_s1_valid && $stable(r_s1_instr),
        "stage 1 lost its instruction under stall")
    `TDP_ASSERT_IMPLY(a_extra_range, i_clk, i_rst_n,
        o_result.valid, o_result.extra_cycles <= 3'd4,
        "extra cycle count out of range")
    `TDP_ASSERT_NEXT(a_flags_follow, i_clk, i_rst_n,
        adv_out, r_flags == {r_out.flag_n, r_out.flag_z, r_out.flag_c, r_out.flag_v},
        "flag register differs from the last result")
endmodule

>>> tb/sv/thumb_data_processing_execute_test.sv
// ----------------------------------------------------------------------------
// thumb_data_processing_execute_test
// Self-checking bench for the Thumb data-processing execute stage. A scoreboard
// class predicts each accepted instruction against its own register file and
// flags, and checks result beats in order. Directed edge cases come first,
// then random instructions under both core variants with random idling.
// ----------------------------------------------------------------------------
module thumb_data_processing_execute_test;

    typedef struct packed {
        logic        recognized;
        logic        write_enable;
        logic [2:0]  dest_index;
        logic [31:0] result_value;
        logic        flag_n;
        logic        flag_z;
        logic        flag_c;
        logic        flag_v;
        logic [2:0]  extra_cycles;
    } t_exec_beat;

    class exec_scoreboard;
        logic [31:0] regs [8];
        logic        n, z, c, v;
        logic        variant;
        t_exec_beat  pending[$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            n = 1'b0; z = 1'b0; c = 1'b0; v = 1'b0; variant = 1'b0; errors = 0;
        endfunction

        function void set_nz(logic [31:0] r);
            n = r[31];
            z = (r == 32'd0);
        endfunction

        function logic [31:0] add_flags(logic [31:0] a, logic [31:0] b, logic cin);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
            set_nz(s[31:0]);
            c = s[32];
            v = (a[31] ^ s[31]) & (b[31] ^ s[31]);
            return s[31:0];
        endfunction

        function logic [31:0] barrel(logic [1:0] kind, logic [31:0] x, logic [8:0] s);
            logic [31:0] r;
            logic [4:0]  m;
            if (s == 0) return x;
            case (kind)
                tdpe_pkg::SH_LSL: begin
                    if (s < 32) begin c = x[32 - s]; return x << s; end
                    c = (s == 32) ? x[0] : 1'b0;
                    return '0;
                end
                tdpe_pkg::SH_LSR: begin
                    if (s < 32) begin c = x[s - 1]; return x >> s; end
                    c = (s == 32) ? x[31] : 1'b0;
                    return '0;
                end
                tdpe_pkg::SH_ASR: begin
                    if (s < 32) begin c = x[s - 1]; return $signed(x) >>> s; end
                    c = x[31];
                    return {32{x[31]}};
                end
                default: begin
                    m = s[4:0];
                    if (m == 0) begin c = x[31]; return x; end
                    r = (x >> m) | (x << (6'd32 - m));
                    c = r[31];
                    return r;
                end
            endcase
        endfunction

        function logic [2:0] mul_count(logic [31:0] x);
            if (x[31:8] == 24'd0 || x[31:8] == 24'hFFFFFF) return 3'd1;
            if (x[31:16] == 16'd0 || x[31:16] == 16'hFFFF) return 3'd2;
            if (x[31:24] == 8'd0 || x[31:24] == 8'hFF) return 3'd3;
            return 3'd4;
        endfunction

        function void note_instr(logic [15:0] w);
            t_exec_beat  e;
            logic [31:0] a, b, val;
            logic [8:0]  amt;
            logic [1:0]  op2;
            logic [3:0]  op4;
            e = '0;
            val = '0;
            if (w[15:13] == 3'b000 && w[12:11] != 2'b11) begin
                amt = {4'd0, w[10:6]};
                if (w[12:11] != tdpe_pkg::SH_LSL && amt == 0) amt = 9'd32;
                e.dest_index = w[2:0];
                val = barrel(w[12:11], regs[w[5:3]], amt);
                set_nz(val);
                e.recognized = 1'b1; e.write_enable = 1'b1;
            end else if (w[15:11] == 5'b00011) begin
                a = regs[w[5:3]];
                b = w[10] ? {29'd0, w[8:6]} : regs[w[8:6]];
                e.dest_index = w[2:0];
                val = w[9] ? add_flags(a, ~b, 1'b1) : add_flags(a, b, 1'b0);
                e.recognized = 1'b1; e.write_enable = 1'b1;
            end else if (w[15:13] == 3'b001) begin
                op2 = w[12:11];
                b = {24'd0, w[7:0]};
                e.dest_index = w[10:8];
                a = regs[w[10:8]];
                e.recognized = 1'b1; e.write_enable = 1'b1;
                case (op2)
                    tdpe_pkg::IMM_MOV: begin val = b; set_nz(val); end
                    tdpe_pkg::IMM_CMP: begin
                        val = add_flags(a, ~b, 1'b1); e.write_enable = 1'b0;
                    end
                    tdpe_pkg::IMM_ADD: val = add_flags(a, b, 1'b0);
                    default: val = add_flags(a, ~b, 1'b1);
                endcase
            end else if (w[15:10] == 6'b010000) begin
                op4 = w[9:6];
                e.dest_index = w[2:0];
                a = regs[w[2:0]];
                b = regs[w[5:3]];
                e.recognized = 1'b1; e.write_enable = 1'b1;
                case (op4)
                    tdpe_pkg::ALU_AND: begin val = a & b; set_nz(val); end
                    tdpe_pkg::ALU_EOR: begin val = a ^ b; set_nz(val); end
                    tdpe_pkg::ALU_LSL, tdpe_pkg::ALU_LSR, tdpe_pkg::ALU_ASR,
                    tdpe_pkg::ALU_ROR: begin
                        val = barrel(op4 == tdpe_pkg::ALU_ROR ? tdpe_pkg::SH_ROR
                                                              : 2'(op4 - 4'd2), a,
                                     {1'b0, b[7:0]});
                        set_nz(val);
                        e.extra_cycles = 3'd1;
                    end
                    tdpe_pkg::ALU_ADC: val = add_flags(a, b, c);
                    tdpe_pkg::ALU_SBC: val = add_flags(a, ~b, c);
                    tdpe_pkg::ALU_TST: begin
                        val = a & b; set_nz(val); e.write_enable = 1'b0;
                    end
                    tdpe_pkg::ALU_NEG: val = add_flags(32'd0, ~b, 1'b1);
                    tdpe_pkg::ALU_CMP: begin
                        val = add_flags(a, ~b, 1'b1); e.write_enable = 1'b0;
                    end
                    tdpe_pkg::ALU_CMN: begin
                        val = add_flags(a, b, 1'b0); e.write_enable = 1'b0;
                    end
                    tdpe_pkg::ALU_ORR: begin val = a | b; set_nz(val); end
                    tdpe_pkg::ALU_MUL: begin
                        val = a * b;
                        set_nz(val);
                        e.extra_cycles = variant ? tdpe_pkg::MUL_CYC_V5 : mul_count(b);
                    end
                    tdpe_pkg::ALU_BIC: begin val = a & ~b; set_nz(val); end
                    default: begin val = ~b; set_nz(val); end
                endcase
            end
            if (e.write_enable) regs[e.dest_index] = val;
            e.result_value = val;
            e.flag_n = n; e.flag_z = z; e.flag_c = c; e.flag_v = v;
            pending.push_back(e);
        endfunction

        function void check_beat(t_exec_beat got);
            t_exec_beat e;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.recognized !== e.recognized) begin
                $error("recognized exp %0h got %0h", e.recognized, got.recognized); errors++;
            end
            if (got.write_enable !== e.write_enable) begin
                $error("write_enable exp %0h got %0h", e.write_enable, got.write_enable);
                errors++;
            end
            if (got.dest_index !== e.dest_index) begin
                $error("dest_index exp %0h got %0h", e.dest_index, got.dest_index); errors++;
            end
            if (got.result_value !== e.result_value) begin
                $error("result_value exp %08h got %08h", e.result_value, got.result_value);
                errors++;
            end
            if (got.flag_n !== e.flag_n) begin
                $error("flag_n exp %0h got %0h", e.flag_n, got.flag_n); errors++;
            end
            if (got.flag_z !== e.flag_z) begin
                $error("flag_z exp %0h got %0h", e.flag_z, got.flag_z); errors++;
            end
            if (got.flag_c !== e.flag_c) begin
                $error("flag_c exp %0h got %0h", e.flag_c, got.flag_c); errors++;
            end
            if (got.flag_v !== e.flag_v) begin
                $error("flag_v exp %0h got %0h", e.flag_v, got.flag_v); errors++;
            end
            if (got.extra_cycles !== e.extra_cycles) begin
                $error("extra_cycles exp %0h got %0h", e.extra_cycles, got.extra_cycles);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;
    int   cycle_count = 0;
    int   hold_off = 0;
    bit   stall_mode = 1'b0;

    tdpe_instr_if  instr_ch ();
    tdpe_result_if result_ch ();

    exec_scoreboard sb = new();

    thumb_data_processing_execute uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_instr     (instr_ch),
        .o_result    (result_ch)
    );

    initial begin
        instr_ch.valid = 1'b0;
        instr_ch.instruction_word = '0;
        result_ch.ready = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 40) return 0;
        if ($urandom_range(0, 99) < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // sink: random backpressure in stall mode, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            sb.check_beat({result_ch.recognized, result_ch.write_enable,
                           result_ch.dest_index, result_ch.result_value,
                           result_ch.flag_n, result_ch.flag_z, result_ch.flag_c,
                           result_ch.flag_v, result_ch.extra_cycles});
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            result_ch.ready <= 1'b0;
        end else if (!stall_mode) begin
            result_ch.ready <= 1'b1;
        end else begin
            result_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 1) == 1);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && instr_ch.valid && instr_ch.ready)
            sb.note_instr(instr_ch.instruction_word);

    // hold valid across back-to-back beats; drop it only for an idle gap
    task automatic send_instr(input logic [15:0] w, input bit idle);
        int g;
        g = idle ? gap_len() : 0;
        if (g > 0) begin
            instr_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        instr_ch.valid <= 1'b1;
        instr_ch.instruction_word <= w;
        @(posedge i_clk);
        while (!instr_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        instr_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_variant(input logic val);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.variant = val;
        @(posedge i_clk);
    endtask

    // load a register with a 32-bit value by MOV, LSL and ADD immediate
    task automatic load_reg(input logic [2:0] r, input logic [31:0] x);
        send_instr({5'b00100, r, x[31:24]}, 1'b0);
        send_instr({5'b00000, 5'd8, r, r}, 1'b0);
        send_instr({5'b00110, r, x[23:16]}, 1'b0);
        send_instr({5'b00000, 5'd8, r, r}, 1'b0);
        send_instr({5'b00110, r, x[15:8]}, 1'b0);
        send_instr({5'b00000, 5'd8, r, r}, 1'b0);
        send_instr({5'b00110, r, x[7:0]}, 1'b0);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFFFFFF;
            2: return 32'h80000000;
            3: return {24'd0, 8'($urandom_range(0, 40))};
            4: return {$urandom_range(0, 1) ? 24'hFFFFFF : 24'd0, 8'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_instr();
        case ($urandom_range(0, 9))
            0, 1: return {3'b000, 2'($urandom_range(0, 2)), 11'($urandom)};
            2: return {5'b00011, 11'($urandom)};
            3, 4: return {3'b001, 13'($urandom)};
            5, 6, 7: return {6'b010000, 10'($urandom)};
            8: return {5'b00100, 3'($urandom), 8'($urandom_range(0, 40))};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(input logic val, input int count);
        int k;
        write_variant(val);
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 29) == 0) load_reg(3'($urandom), rand_word());
            else send_instr(rand_instr(), stall_mode);
        end
        drain();
    endtask

    initial begin
        int k;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, shift corner cases, every ALU op, a MUL cycle count
        load_reg(3'd1, 32'h80000001);
        load_reg(3'd2, 32'd32);
        send_instr({5'b00001, 5'd0, 3'd1, 3'd3}, 1'b0);
        send_instr({5'b00010, 5'd0, 3'd1, 3'd4}, 1'b0);
        send_instr({5'b00000, 5'd0, 3'd1, 3'd5}, 1'b0);
        send_instr(16'hFFFF, 1'b0);
        send_instr({5'b00111, 3'd7, 8'hFF}, 1'b0);
        for (k = 0; k < 16; k++)
            send_instr({6'b010000, 4'(k), 3'd2, 3'd1}, 1'b0);
        drain();

        // long sink hold-off with the source pushing, then a source pause
        hold_off = 60;
        for (k = 0; k < 20; k++) send_instr(rand_instr(), 1'b0);
        drain();

        stall_mode = 1'b1;
        run_phase(1'b1, 320);
        run_phase(1'b0, 320);
        stall_mode = 1'b0;
        run_phase(1'b1, 150);
        stall_mode = 1'b1;
        run_phase(1'b0, 320);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
